>>> hdl/ipbp_pkg.sv
// ----------------------------------------------------------------------------
// ipbp_pkg
// Shared types, constants and a saturation helper for the image point back-projection block
// ----------------------------------------------------------------------------
package ipbp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int COEF_WORDS    = 33;
    localparam int PIX_FRAC      = 4;
    localparam int KINV_BASE     = 0;
    localparam int CAM2BASE_BASE = 9;
    localparam int POSE_BASE     = 21;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ODEPTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXDEPTH  = 3'd4;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_PROJ  = 1'b1;

    localparam logic [1:0] DSEL_EST   = 2'd0;
    localparam logic [1:0] DSEL_MINUS = 2'd1;
    localparam logic [1:0] DSEL_PLUS  = 2'd2;

    localparam logic FSEL_WORLD = 1'b0;
    localparam logic FSEL_BASE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DIV0  = 2'd2;

    typedef struct packed {
        logic               action;
        logic [5:0]         coef_index;
        logic signed [31:0] coef_value;
        logic [15:0]        pixel_u;
        logic [15:0]        pixel_v;
        logic [15:0]        width_px;
        logic [1:0]         depth_select;
        logic               frame_select;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [1:0]         status;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hdl/ipbp_if.sv
// ----------------------------------------------------------------------------
// ipbp_if
// Valid/ready stream interfaces for input items and result items
// ----------------------------------------------------------------------------
interface ipbp_in_if;
    logic                valid;
    logic                ready;
    ipbp_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipbp_out_if;
    logic                valid;
    logic                ready;
    ipbp_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/ipbp_dly.sv
// ----------------------------------------------------------------------------
// ipbp_dly
// Enabled shift line that keeps side data level with a divider
// ----------------------------------------------------------------------------
module ipbp_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_tap[k] <= '0;
        end else if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_d = r_tap[DEPTH-1];

endmodule

>>> hdl/ipbp_div.sv
// ----------------------------------------------------------------------------
// ipbp_div
// Pipelined restoring divider, one quotient bit per stage, unsigned
// ----------------------------------------------------------------------------
module ipbp_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_acc [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic [NUM_W-1:0] acc_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W+1:0] diff;

        if (s == 0) begin : g_first
            assign acc_in = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign acc_in = r_acc[s-1];
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
        end

        // trial subtract of the divisor from the shifted partial remainder
        assign diff = {1'b0, rem_in, acc_in[NUM_W-1]} - {2'b00, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                if (!diff[DEN_W+1]) begin
                    r_rem[s] <= diff[DEN_W-1:0];
                    r_acc[s] <= {acc_in[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s] <= {rem_in[DEN_W-2:0], acc_in[NUM_W-1]};
                    r_acc[s] <= {acc_in[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_acc[NUM_W-1];

endmodule

>>> hdl/image_point_back_projection_top.sv
// ----------------------------------------------------------------------------
// image_point_back_projection_top
// Back-projects image points to 3-D through depth estimate, ray and transforms
// ----------------------------------------------------------------------------
// The path from input transfer to result valid runs mostly through the two
// bit-per-stage dividers (64 stages for depth, 63 for the ray scaling)
// throughput: one projection per cycle unless the output stalls; a coefficient
// write waits until no projection is in flight ahead of the output register
// reset: synchronous active low, registers to reset values, coefficients
// undefined until written
module image_point_back_projection_top #(
    parameter int FRAC_BITS  = ipbp_pkg::FRAC_BITS,
    parameter int COEF_WORDS = ipbp_pkg::COEF_WORDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ipbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ipbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ipbp_in_if.sink                           i_pt,
    ipbp_out_if.source                        o_pt
);

    localparam int DZ_W  = 64;
    localparam int DXY_W = 63;
    localparam int ZSH   = FRAC_BITS - ipbp_pkg::PIX_FRAC;
    localparam int LAT   = 136;
    localparam int CNT_W = $clog2(LAT + 1);
    localparam int KINV_N = ipbp_pkg::CAM2BASE_BASE - ipbp_pkg::KINV_BASE;
    localparam int C2B_N  = ipbp_pkg::POSE_BASE - ipbp_pkg::CAM2BASE_BASE;
    localparam int POSE_N = COEF_WORDS - ipbp_pkg::POSE_BASE;

    // configuration
    logic [31:0] r_focal, r_owidth, r_odepth, r_margin, r_maxdepth;
    logic [63:0] r_prod;
    logic [32:0] r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal    <= '0;
            r_owidth   <= '0;
            r_odepth   <= '0;
            r_margin   <= '0;
            r_maxdepth <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ipbp_pkg::CFG_FOCAL:    r_focal    <= i_cfg_data;
                ipbp_pkg::CFG_OWIDTH:   r_owidth   <= i_cfg_data;
                ipbp_pkg::CFG_ODEPTH:   r_odepth   <= i_cfg_data;
                ipbp_pkg::CFG_MARGIN:   r_margin   <= i_cfg_data;
                ipbp_pkg::CFG_MAXDEPTH: r_maxdepth <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= 64'(r_focal) * 64'(r_owidth);
        r_shift <= {1'b0, r_odepth} + {1'b0, r_margin};
    end

    // handshake and in-flight count
    logic             en;
    logic             acc;
    logic             acc_proj;
    logic             acc_wr;
    logic             r_ovalid;
    logic             r135_vld;
    logic [CNT_W-1:0] r_inflight;

    assign en       = !r_ovalid || o_pt.ready;
    assign i_pt.ready = en && (i_pt.data.action == ipbp_pkg::ACT_PROJ || r_inflight == '0);
    assign acc      = i_pt.valid && i_pt.ready;
    assign acc_proj = acc && (i_pt.data.action == ipbp_pkg::ACT_PROJ);
    assign acc_wr   = acc && (i_pt.data.action == ipbp_pkg::ACT_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + CNT_W'(acc_proj) - CNT_W'(en && r135_vld);
        end
    end

    // coefficient store, one bank per matrix, each word read at a fixed stage
    logic signed [31:0] r_kinv [KINV_N];
    logic signed [31:0] r_c2b  [C2B_N];
    logic signed [31:0] r_pose [POSE_N];
    logic [5:0]         wr_idx;

    assign wr_idx = i_pt.data.coef_index;

    always_ff @(posedge i_clk) begin
        if (acc_wr) begin
            if (32'(wr_idx) < ipbp_pkg::CAM2BASE_BASE) begin
                r_kinv[4'(wr_idx - 6'(ipbp_pkg::KINV_BASE))] <= i_pt.data.coef_value;
            end else if (32'(wr_idx) < ipbp_pkg::POSE_BASE) begin
                r_c2b[4'(wr_idx - 6'(ipbp_pkg::CAM2BASE_BASE))] <= i_pt.data.coef_value;
            end else if (32'(wr_idx) < COEF_WORDS) begin
                r_pose[4'(wr_idx - 6'(ipbp_pkg::POSE_BASE))] <= i_pt.data.coef_value;
            end
        end
    end

    // stage 1
    logic        r1_vld;
    logic [15:0] r1_u, r1_v, r1_wpx;
    logic [1:0]  r1_dsel;
    logic        r1_fsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= acc_proj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_u    <= i_pt.data.pixel_u;
            r1_v    <= i_pt.data.pixel_v;
            r1_wpx  <= i_pt.data.width_px;
            r1_dsel <= i_pt.data.depth_select;
            r1_fsel <= i_pt.data.frame_select;
        end
    end

    // depth division
    logic [DZ_W-1:0] q_z;

    ipbp_div #(.NUM_W(DZ_W), .DEN_W(16)) u_div_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_prod),
        .i_den (r1_wpx),
        .o_quo (q_z)
    );

    logic [4:0] side_a;

    ipbp_dly #(.WIDTH(5), .DEPTH(DZ_W)) u_dly_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_d     ({r1_vld, r1_wpx == 16'd0, r1_dsel, r1_fsel}),
        .o_d     (side_a)
    );

    // ray through inverse intrinsics
    logic signed [48:0] r2_pu [3];
    logic signed [48:0] r2_pv [3];
    logic signed [31:0] r2_k2 [3];
    logic signed [31:0] r3_ray [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_pu[i] <= 49'(r_kinv[3*i]) * 49'($signed({1'b0, r1_u}));
                r2_pv[i] <= 49'(r_kinv[3*i + 1]) * 49'($signed({1'b0, r1_v}));
                r2_k2[i] <= r_kinv[3*i + 2];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_ray[i] <= ipbp_pkg::sat32(66'((52'(r2_pu[i]) + 52'(r2_pv[i])
                             + (52'(r2_k2[i]) <<< ipbp_pkg::PIX_FRAC))
                             >>> ipbp_pkg::PIX_FRAC));
            end
        end
    end

    logic [95:0] ray_d;

    ipbp_dly #(.WIDTH(96), .DEPTH(DZ_W - 2)) u_dly_ray (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_d     ({r3_ray[0], r3_ray[1], r3_ray[2]}),
        .o_d     (ray_d)
    );

    // depth limit, selected depth and status
    logic [DZ_W-1:0]    z;
    logic signed [34:0] zs, sh, d35;
    logic [1:0]         st;

    assign z  = q_z >> ZSH;
    assign zs = $signed({3'b000, z[31:0]});
    assign sh = $signed({2'b00, r_shift});

    always_comb begin
        unique case (side_a[2:1])
            ipbp_pkg::DSEL_MINUS: d35 = zs - sh;
            ipbp_pkg::DSEL_PLUS:  d35 = zs + sh;
            default:              d35 = zs;
        endcase
        priority if (side_a[3]) begin
            st = ipbp_pkg::ST_DIV0;
        end else if (z > {32'd0, r_maxdepth}) begin
            st = ipbp_pkg::ST_RANGE;
        end else if (ray_d[31:0] == 32'd0) begin
            st = ipbp_pkg::ST_DIV0;
        end else begin
            st = ipbp_pkg::ST_OK;
        end
    end

    logic               r66_vld, r66_fsel;
    logic [1:0]         r66_st;
    logic signed [31:0] r66_d, r66_r0, r66_r1, r66_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r66_vld <= 1'b0;
        end else if (en) begin
            r66_vld <= side_a[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r66_fsel <= side_a[0];
            r66_st   <= st;
            r66_d    <= ipbp_pkg::sat32(66'(d35));
            r66_r0   <= ray_d[95:64];
            r66_r1   <= ray_d[63:32];
            r66_r2   <= ray_d[31:0];
        end
    end

    // scale the ray by depth
    logic               r67_vld, r67_fsel;
    logic [1:0]         r67_st;
    logic signed [31:0] r67_d, r67_r2;
    logic signed [63:0] r67_p0, r67_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r67_vld <= 1'b0;
        end else if (en) begin
            r67_vld <= r66_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r67_fsel <= r66_fsel;
            r67_st   <= r66_st;
            r67_d    <= r66_d;
            r67_r2   <= r66_r2;
            r67_p0   <= 64'(r66_d) * 64'(r66_r0);
            r67_p1   <= 64'(r66_d) * 64'(r66_r1);
        end
    end

    logic               r68_vld, r68_fsel, r68_sx, r68_sy;
    logic [1:0]         r68_st;
    logic signed [31:0] r68_d;
    logic [62:0]        r68_m0, r68_m1;
    logic [31:0]        r68_den;
    logic signed [63:0] n0, n1;
    logic signed [31:0] nr2;

    assign n0  = -r67_p0;
    assign n1  = -r67_p1;
    assign nr2 = -r67_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r68_vld <= 1'b0;
        end else if (en) begin
            r68_vld <= r67_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r68_fsel <= r67_fsel;
            r68_st   <= r67_st;
            r68_d    <= r67_d;
            r68_m0   <= r67_p0[63] ? n0[62:0] : r67_p0[62:0];
            r68_m1   <= r67_p1[63] ? n1[62:0] : r67_p1[62:0];
            r68_den  <= r67_r2[31] ? nr2 : r67_r2;
            r68_sx   <= r67_p0[63] ^ r67_r2[31];
            r68_sy   <= r67_p1[63] ^ r67_r2[31];
        end
    end

    logic [DXY_W-1:0] q_x, q_y;

    ipbp_div #(.NUM_W(DXY_W), .DEN_W(32)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r68_m0),
        .i_den (r68_den),
        .o_quo (q_x)
    );

    ipbp_div #(.NUM_W(DXY_W), .DEN_W(32)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r68_m1),
        .i_den (r68_den),
        .o_quo (q_y)
    );

    logic [37:0] side_b;

    ipbp_dly #(.WIDTH(38), .DEPTH(DXY_W)) u_dly_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_d     ({r68_vld, r68_fsel, r68_st, r68_sx, r68_sy, r68_d}),
        .o_d     (side_b)
    );

    // camera point
    logic               r132_vld, r132_fsel;
    logic [1:0]         r132_st;
    logic signed [31:0] r132_c [3];
    logic signed [65:0] qx_s, qy_s;

    assign qx_s = side_b[33] ? -$signed({3'b000, q_x}) : $signed({3'b000, q_x});
    assign qy_s = side_b[32] ? -$signed({3'b000, q_y}) : $signed({3'b000, q_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r132_vld <= 1'b0;
        end else if (en) begin
            r132_vld <= side_b[37];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r132_fsel <= side_b[36];
            r132_st   <= side_b[35:34];
            r132_c[0] <= ipbp_pkg::sat32(qx_s);
            r132_c[1] <= ipbp_pkg::sat32(qy_s);
            r132_c[2] <= side_b[31:0];
        end
    end

    // camera to base
    logic               r133_vld, r133_fsel;
    logic [1:0]         r133_st;
    logic signed [63:0] r133_p [3][3];
    logic signed [31:0] r133_t [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r133_vld <= 1'b0;
        end else if (en) begin
            r133_vld <= r132_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r133_fsel <= r132_fsel;
            r133_st   <= r132_st;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r133_p[r][c] <= 64'(r_c2b[4*r + c]) * 64'(r132_c[c]);
                end
                r133_t[r] <= r_c2b[4*r + 3];
            end
        end
    end

    logic               r134_vld, r134_fsel;
    logic [1:0]         r134_st;
    logic signed [31:0] r134_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r134_vld <= 1'b0;
        end else if (en) begin
            r134_vld <= r133_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r134_fsel <= r133_fsel;
            r134_st   <= r133_st;
            for (int r = 0; r < 3; r++) begin
                r134_b[r] <= ipbp_pkg::sat32((66'(r133_p[r][0]) >>> FRAC_BITS)
                             + (66'(r133_p[r][1]) >>> FRAC_BITS)
                             + (66'(r133_p[r][2]) >>> FRAC_BITS) + 66'(r133_t[r]));
            end
        end
    end

    // base to world
    logic               r135_fsel;
    logic [1:0]         r135_st;
    logic signed [63:0] r135_p [3][3];
    logic signed [31:0] r135_t [3];
    logic signed [31:0] r135_b [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r135_vld <= 1'b0;
        end else if (en) begin
            r135_vld <= r134_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r135_fsel <= r134_fsel;
            r135_st   <= r134_st;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r135_p[r][c] <= 64'(r_pose[4*r + c]) * 64'(r134_b[c]);
                end
                r135_t[r] <= r_pose[4*r + 3];
                r135_b[r] <= r134_b[r];
            end
        end
    end

    // output register
    logic signed [31:0] w [3];
    logic signed [31:0] sel [3];
    ipbp_pkg::t_out_item r_out;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w[r] = ipbp_pkg::sat32((66'(r135_p[r][0]) >>> FRAC_BITS)
                   + (66'(r135_p[r][1]) >>> FRAC_BITS)
                   + (66'(r135_p[r][2]) >>> FRAC_BITS) + 66'(r135_t[r]));
            if (r135_st != ipbp_pkg::ST_OK) begin
                sel[r] = '0;
            end else if (r135_fsel == ipbp_pkg::FSEL_WORLD) begin
                sel[r] = w[r];
            end else begin
                sel[r] = r135_b[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r135_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.point_x <= sel[0];
            r_out.point_y <= sel[1];
            r_out.point_z <= sel[2];
            r_out.status  <= r135_st;
        end
    end

    assign o_pt.valid = r_ovalid;
    assign o_pt.data  = r_out;

    // checks
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_wr |-> r_inflight == '0)
        else $error("coefficient write taken with projections in flight");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r135_vld) |-> (r_inflight != '0))
        else $error("in-flight count underflow");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && o_pt.data.status != ipbp_pkg::ST_OK) |->
        (o_pt.data.point_x == '0 && o_pt.data.point_y == '0 && o_pt.data.point_z == '0))
        else $error("failed projection carries a nonzero point");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && !o_pt.ready) |=> (o_pt.valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

>>> verif/tb_image_point_back_projection_top.sv
// ----------------------------------------------------------------------------
// tb_image_point_back_projection_top
// Self-checking bench: loads the coefficient store, then runs several register
// settings with random items, directed ones in two, against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_image_point_back_projection_top;

    localparam int RUN_LIMIT  = 600000;
    localparam int DRAIN_WAIT = 160;
    localparam int CHOKE_LEN  = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ipbp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ipbp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    ipbp_in_if  pt_in ();
    ipbp_out_if pt_out ();

    image_point_back_projection_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pt        (pt_in.sink),
        .o_pt        (pt_out.source)
    );

    initial begin
        pt_in.valid  = 1'b0;
        pt_in.data   = '0;
        pt_out.ready = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0]        focal_q, owidth_q, odepth_q, margin_q, maxdepth_q;
    logic signed [31:0] coef_mem [ipbp_pkg::COEF_WORDS];

    ipbp_pkg::t_in_item  pending_items [$];
    ipbp_pkg::t_out_item expected_points [$];
    int        errors = 0;
    int        cycles = 0;
    bit        no_idle = 1'b0;
    bit        choke_req = 1'b0;
    bit        choke_done = 1'b0;
    int        choke_left = 0;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic void queue_item(ipbp_pkg::t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint coef_at(int k);
        return longint'(coef_mem[k]);
    endfunction

    function automatic void rigid_map(int base, longint p[3], output longint q[3]);
        longint s;
        for (int r = 0; r < 3; r++) begin
            s = ((coef_at(base + 4*r) * p[0]) >>> ipbp_pkg::FRAC_BITS)
              + ((coef_at(base + 4*r + 1) * p[1]) >>> ipbp_pkg::FRAC_BITS)
              + ((coef_at(base + 4*r + 2) * p[2]) >>> ipbp_pkg::FRAC_BITS)
              + coef_at(base + 4*r + 3);
            q[r] = clip32(s);
        end
    endfunction

    function automatic ipbp_pkg::t_out_item back_project(ipbp_pkg::t_in_item it);
        ipbp_pkg::t_out_item res;
        logic [63:0] prod, z;
        longint      d, shift, s, uu, vv;
        longint      ray [3];
        longint      cam [3];
        longint      base_pt [3];
        longint      world [3];
        res = '0;
        res.status = ipbp_pkg::ST_OK;
        if (it.width_px == 16'd0) begin
            res.status = ipbp_pkg::ST_DIV0;
        end else begin
            prod = {32'b0, focal_q} * {32'b0, owidth_q};
            z = (prod / {48'b0, it.width_px}) >> (ipbp_pkg::FRAC_BITS - ipbp_pkg::PIX_FRAC);
            if (z > {32'b0, maxdepth_q}) begin
                res.status = ipbp_pkg::ST_RANGE;
            end else begin
                d = longint'(z);
                shift = longint'({32'b0, odepth_q}) + longint'({32'b0, margin_q});
                if (it.depth_select == ipbp_pkg::DSEL_MINUS) d = d - shift;
                else if (it.depth_select == ipbp_pkg::DSEL_PLUS) d = d + shift;
                d = clip32(d);
                uu = longint'({48'b0, it.pixel_u});
                vv = longint'({48'b0, it.pixel_v});
                for (int i = 0; i < 3; i++) begin
                    s = coef_at(ipbp_pkg::KINV_BASE + 3*i) * uu
                      + coef_at(ipbp_pkg::KINV_BASE + 3*i + 1) * vv
                      + coef_at(ipbp_pkg::KINV_BASE + 3*i + 2)
                        * (64'sd1 <<< ipbp_pkg::PIX_FRAC);
                    ray[i] = clip32(s >>> ipbp_pkg::PIX_FRAC);
                end
                if (ray[2] == 0) begin
                    res.status = ipbp_pkg::ST_DIV0;
                end else begin
                    cam[0] = clip32((d * ray[0]) / ray[2]);
                    cam[1] = clip32((d * ray[1]) / ray[2]);
                    cam[2] = d;
                    rigid_map(ipbp_pkg::CAM2BASE_BASE, cam, base_pt);
                    if (it.frame_select == ipbp_pkg::FSEL_WORLD)
                        rigid_map(ipbp_pkg::POSE_BASE, base_pt, world);
                    else world = base_pt;
                    res.point_x = world[0][31:0];
                    res.point_y = world[1][31:0];
                    res.point_z = world[2][31:0];
                end
            end
        end
        return res;
    endfunction

    function automatic void absorb_item(ipbp_pkg::t_in_item it);
        if (it.action == ipbp_pkg::ACT_WRITE) begin
            if (it.coef_index < ipbp_pkg::COEF_WORDS) coef_mem[it.coef_index] = it.coef_value;
        end else begin
            expected_points.insert(expected_points.size(), back_project(it));
        end
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input side driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            pt_in.valid <= 1'b0;
        end else if (!(pt_in.valid && !pt_in.ready)) begin
            if (pt_in.valid && pt_in.ready) begin
                absorb_item(pt_in.data);
                void'(pending_items.pop_front());
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                pt_in.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                pt_in.valid <= 1'b1;
                pt_in.data  <= pending_items[0];
                send_gap    <= idle_len();
            end else begin
                pt_in.valid <= 1'b0;
            end
        end
        if (cycles > RUN_LIMIT) begin
            $display("tb_image_point_back_projection_top: done, errors");
            $finish;
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    always @(posedge i_clk) begin
        if (choke_req && !choke_done) begin
            choke_left <= CHOKE_LEN;
            choke_done <= 1'b1;
        end else if (choke_left > 0) begin
            choke_left <= choke_left - 1;
        end
    end

    // result side: ready pattern and checking
    always @(posedge i_clk) begin
        ipbp_pkg::t_out_item want;
        if (!i_rst_n) begin
            pt_out.ready <= 1'b0;
        end else begin
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                pt_out.ready <= 1'b0;
            end else begin
                pt_out.ready <= (choke_left == 0);
                recv_gap <= idle_len();
            end
            if (pt_out.valid && pt_out.ready) begin
                if (expected_points.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none actual %h", $time,
                             pt_out.data);
                end else begin
                    want = expected_points.pop_front();
                    if (want.point_x !== pt_out.data.point_x) begin
                        errors = errors + 1;
                        $display("%0t: point_x expected %h actual %h", $time,
                                 want.point_x, pt_out.data.point_x);
                    end
                    if (want.point_y !== pt_out.data.point_y) begin
                        errors = errors + 1;
                        $display("%0t: point_y expected %h actual %h", $time,
                                 want.point_y, pt_out.data.point_y);
                    end
                    if (want.point_z !== pt_out.data.point_z) begin
                        errors = errors + 1;
                        $display("%0t: point_z expected %h actual %h", $time,
                                 want.point_z, pt_out.data.point_z);
                    end
                    if (want.status !== pt_out.data.status) begin
                        errors = errors + 1;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, pt_out.data.status);
                    end
                end
            end
        end
    end

    function automatic ipbp_pkg::t_in_item coef_write(int idx, logic [31:0] val);
        ipbp_pkg::t_in_item it;
        it = '0;
        it.action     = ipbp_pkg::ACT_WRITE;
        it.coef_index = idx[5:0];
        it.coef_value = val;
        it.pixel_u    = 16'($urandom());
        it.pixel_v    = 16'($urandom());
        it.width_px   = 16'($urandom());
        return it;
    endfunction

    function automatic ipbp_pkg::t_in_item point(logic [15:0] u, logic [15:0] v,
                                                 logic [15:0] w, logic [1:0] dsel,
                                                 logic fsel);
        ipbp_pkg::t_in_item it;
        it = '0;
        it.action       = ipbp_pkg::ACT_PROJ;
        it.coef_index   = 6'($urandom());
        it.coef_value   = $urandom();
        it.pixel_u      = u;
        it.pixel_v      = v;
        it.width_px     = w;
        it.depth_select = dsel;
        it.frame_select = fsel;
        return it;
    endfunction

    function automatic logic [31:0] plausible_coef(int idx);
        int col;
        if (idx < ipbp_pkg::CAM2BASE_BASE) begin
            case (idx)
                0, 4:    return $urandom_range(40, 300);
                2, 5:    return -$urandom_range(1000, 60000);
                6, 7:    return $urandom_range(0, 3) - 1;
                8:       return 32'sh0001_0000;
                default: return $urandom_range(0, 8) - 4;
            endcase
        end
        col = (idx - ((idx < ipbp_pkg::POSE_BASE) ? ipbp_pkg::CAM2BASE_BASE
                                                  : ipbp_pkg::POSE_BASE)) % 4;
        if (col == 3) return $urandom_range(0, 1 << 21) - (1 << 20);
        return $urandom_range(0, 1 << 17) - (1 << 16);
    endfunction

    task automatic load_coefficients();
        for (int k = 0; k < ipbp_pkg::COEF_WORDS; k++)
            queue_item(coef_write(k, plausible_coef(k)));
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || pt_in.valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [31:0] f, logic [31:0] ow, logic [31:0] od,
                                logic [31:0] mg, logic [31:0] mx);
        logic [31:0] vals [5];
        logic [ipbp_pkg::CFG_IDX_W-1:0] idxs [5];
        vals = '{f, ow, od, mg, mx};
        idxs = '{ipbp_pkg::CFG_FOCAL, ipbp_pkg::CFG_OWIDTH, ipbp_pkg::CFG_ODEPTH,
                 ipbp_pkg::CFG_MARGIN, ipbp_pkg::CFG_MAXDEPTH};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idxs[i];
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        focal_q = f; owidth_q = ow; odepth_q = od; margin_q = mg; maxdepth_q = mx;
    endtask

    task automatic random_items(int count);
        int r, idx;
        logic [15:0] w;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                idx = ($urandom_range(0, 99) < 85)
                    ? $urandom_range(0, ipbp_pkg::COEF_WORDS - 1)
                    : $urandom_range(ipbp_pkg::COEF_WORDS, 63);
                queue_item(coef_write(idx, ($urandom_range(0, 9) < 7) ?
                           plausible_coef(idx % ipbp_pkg::COEF_WORDS) : $urandom()));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) w = 16'd0;
                else if (r < 60) w = 16'($urandom_range(16, 2000));
                else w = 16'($urandom());
                queue_item(point(16'($urandom()), 16'($urandom()), w,
                                 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial begin
        focal_q = '0; owidth_q = '0; odepth_q = '0; margin_q = '0; maxdepth_q = '1;
        for (int k = 0; k < ipbp_pkg::COEF_WORDS; k++) coef_mem[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset values: depth estimate is always zero
        load_coefficients();
        queue_item(point(16'd0, 16'd0, 16'd0, ipbp_pkg::DSEL_EST, ipbp_pkg::FSEL_WORLD));
        queue_item(point(16'hffff, 16'hffff, 16'hffff, ipbp_pkg::DSEL_PLUS,
                         ipbp_pkg::FSEL_BASE));
        random_items(100);
        wait_idle();

        // typical camera
        program_regs(32'd600 << 16, 32'd19661, 32'd6554, 32'd3277, 32'd20 << 16);
        for (int s = 0; s < 4; s++) begin
            queue_item(point(16'd5120, 16'd3840, 16'd800, s[1:0], ipbp_pkg::FSEL_WORLD));
            queue_item(point(16'd5120, 16'd3840, 16'd800, s[1:0], ipbp_pkg::FSEL_BASE));
        end
        queue_item(point(16'd100, 16'd100, 16'd1, ipbp_pkg::DSEL_EST, ipbp_pkg::FSEL_WORLD));
        queue_item(point(16'd0, 16'hffff, 16'd0, ipbp_pkg::DSEL_MINUS,
                         ipbp_pkg::FSEL_WORLD));
        // zero third ray component
        for (int k = 6; k < 9; k++) queue_item(coef_write(k, 32'd0));
        queue_item(point(16'd2000, 16'd2000, 16'd400, ipbp_pkg::DSEL_EST,
                         ipbp_pkg::FSEL_WORLD));
        queue_item(coef_write(8, 32'sh0001_0000));
        // writes outside the store are dropped, then extreme values inside it
        queue_item(coef_write(ipbp_pkg::COEF_WORDS, 32'h8000_0000));
        queue_item(coef_write(63, 32'h7fff_ffff));
        queue_item(coef_write(ipbp_pkg::CAM2BASE_BASE, 32'h7fff_ffff));
        queue_item(coef_write(ipbp_pkg::POSE_BASE + 3, 32'h8000_0000));
        queue_item(point(16'hffff, 16'd0, 16'd16, ipbp_pkg::DSEL_PLUS,
                         ipbp_pkg::FSEL_WORLD));
        random_items(140);
        wait_idle();

        // everything at full scale, back to back with a long output hold-off
        program_regs('1, '1, '1, '1, '1);
        no_idle = 1'b1;
        random_items(150);
        choke_req = 1'b1;
        wait_idle();
        no_idle = 1'b0;

        // zero depth limit: anything but a zero estimate is out of range
        program_regs($urandom(), $urandom(), 32'd0, 32'd0, 32'd0);
        random_items(140);
        wait_idle();

        program_regs($urandom_range(100, 2000) << 16, $urandom_range(1000, 200000),
                     $urandom(), $urandom(), $urandom());
        random_items(140);
        wait_idle();

        if (errors == 0) begin
            $display("tb_image_point_back_projection_top: done, clean");
        end else begin
            $display("tb_image_point_back_projection_top: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/ipbp_pkg.sv
hdl/ipbp_if.sv
hdl/ipbp_dly.sv
hdl/ipbp_div.sv
hdl/image_point_back_projection_top.sv
verif/tb_image_point_back_projection_top.sv
